>>> rtl/core/aled_pkg.sv
// shared types and constants of the addressable led strip driver
`default_nettype none
package aled_pkg;

  // storage size
  localparam int LedMax      = 64;
  localparam int LedIdxW     = (LedMax > 1) ? $clog2(LedMax) : 1;
  localparam int LedCntW     = $clog2(LedMax + 1);
  localparam int BytesPerLed = 3;

  // field widths
  localparam int CmdW        = 2;
  localparam int IdxInW      = 8;
  localparam int ColorW      = 24;
  localparam int CountFieldW = 7;
  localparam int PulseW      = 10;
  localparam int TickW       = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  // command codes on the input word
  localparam logic [CmdW-1:0] CmdSetColor = 2'd0;
  localparam logic [CmdW-1:0] CmdRefresh  = 2'd1;
  localparam logic [CmdW-1:0] CmdTick     = 2'd2;
  localparam logic [CmdW-1:0] CmdNop      = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLedCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongTicks  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgShortTicks = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLatchTicks = 2'd3;

  // configuration reset values
  localparam logic [PulseW-1:0] LongTicksRst  = 10'd72;
  localparam logic [PulseW-1:0] ShortTicksRst = 10'd18;
  localparam logic [TickW-1:0]  LatchTicksRst = 16'd20520;

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KindSet,
    KindRefresh,
    KindTick,
    KindNop
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                idx_ok;
    logic [LedIdxW-1:0]  idx;
    logic [ColorW-1:0]   color;
  } item_t;

  typedef struct packed {
    logic [LedCntW-1:0] led_count;
    logic [PulseW-1:0]  long_ticks;
    logic [PulseW-1:0]  short_ticks;
    logic [TickW-1:0]   latch_ticks;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/aled_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module aled_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                  wdata_i,
  input  wire logic                              re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                  rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/aled_front.sv
// front end: accepts input words and classifies them for the queue
`default_nettype none
module aled_front
  import aled_pkg::*;
(
  input  wire logic              in_valid_i,
  input  wire logic [CmdW-1:0]   command_i,
  input  wire logic [IdxInW-1:0] led_index_i,
  input  wire logic [ColorW-1:0] color_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              q_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output item_t                  item_o
);

  logic idx_ok;

  // range check against live count and store size
  assign idx_ok = (led_index_i < IdxInW'(cfg_i.led_count)) &&
                  (led_index_i < IdxInW'(LedMax));

  always_comb begin
    item_o.idx_ok = idx_ok;
    item_o.idx    = led_index_i[LedIdxW-1:0];
    item_o.color  = color_i;
    case (command_i)
      CmdSetColor: item_o.kind = KindSet;
      CmdRefresh:  item_o.kind = KindRefresh;
      CmdTick:     item_o.kind = KindTick;
      CmdNop:      item_o.kind = KindNop;
      default:     item_o.kind = KindNop;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule
`default_nettype wire

>>> rtl/core/aled_queue.sv
// short fifo of classified words between front and back
`default_nettype none
module aled_queue
  import aled_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       head_valid_o,
  output item_t      head_o
);

  item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/aled_back.sv
// back end: colour store, frame sequencer and result register
`default_nettype none
module aled_back
  import aled_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  head_valid_i,
  input  wire item_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic       pin_level_o,
  output logic       busy_res_o,
  output logic       rejected_o
);

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhHigh  = 2'd1;
  localparam logic [1:0] PhLow   = 2'd2;
  localparam logic [1:0] PhLatch = 2'd3;

  localparam logic [1:0] SubLast = 2'(BytesPerLed - 1);

  function automatic logic [PulseW-1:0] pulse_len(input logic [PulseW-1:0] v);
    pulse_len = (v == '0) ? PulseW'(1) : v;
  endfunction

  function automatic logic [TickW-1:0] latch_len(input logic [TickW-1:0] v);
    latch_len = (v == '0) ? TickW'(1) : v;
  endfunction

  logic [1:0]          phase_q, phase_d;
  logic [LedCntW-1:0]  led_q, led_d;
  logic [1:0]          sub_q, sub_d;
  logic [2:0]          bit_q, bit_d;
  logic [TickW-1:0]    ticks_q, ticks_d;
  logic                pend_q, pend_d;
  logic [PulseW-1:0]   snap_long_q, snap_long_d;
  logic [PulseW-1:0]   snap_short_q, snap_short_d;
  logic                rd_pend_q;
  logic                hit_q;
  logic [ColorW-1:0]   word_q;
  logic [LedMax-1:0]   vld_q, vld_d;
  logic                out_valid_q;
  logic                pin_level_q, busy_res_q, rejected_q;

  logic                take;
  logic [ColorW-1:0]   cur_word;
  logic [7:0]          cur_byte;
  logic                cur_bit;
  logic [TickW-1:0]    left;
  logic [TickW-1:0]    left_dec;
  logic [LedCntW-1:0]  led_next;
  logic [LedCntW-1:0]  led_new;
  logic                go_high, go_latch;
  logic                ram_we, ram_re;
  logic [LedIdxW-1:0]  ram_raddr;
  logic [ColorW-1:0]   ram_rdata;
  logic                lvl, bsy, rej;

  aled_ram #(
    .Width (ColorW),
    .Depth (LedMax)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.idx),
    .wdata_i (head_i.color),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign take  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = take;

  // fresh read data bypasses the word register while the read is pending
  assign cur_word = rd_pend_q ? (hit_q ? ram_rdata : '0) : word_q;

  always_comb begin
    case (sub_q)
      2'd0:    cur_byte = cur_word[15:8];
      2'd1:    cur_byte = cur_word[23:16];
      default: cur_byte = cur_word[7:0];
    endcase
  end

  // msb first: bit 7 - n is ~n on three bits
  assign cur_bit  = cur_byte[~bit_q];
  assign led_next = led_q + LedCntW'(1);

  always_comb begin
    phase_d      = phase_q;
    led_d        = led_q;
    sub_d        = sub_q;
    bit_d        = bit_q;
    ticks_d      = ticks_q;
    pend_d       = pend_q;
    snap_long_d  = snap_long_q;
    snap_short_d = snap_short_q;
    vld_d        = vld_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    go_high      = 1'b0;
    go_latch     = 1'b0;
    rej          = 1'b0;
    led_new      = led_q;
    left         = (phase_q == PhHigh && pend_q) ?
                   TickW'(cur_bit ? snap_long_q : snap_short_q) : ticks_q;
    left_dec     = (left != '0) ? left - TickW'(1) : '0;

    if (take) begin
      case (head_i.kind)
        KindSet: begin
          if (phase_q != PhIdle || !head_i.idx_ok) begin
            rej = 1'b1;
          end else begin
            ram_we             = 1'b1;
            vld_d[head_i.idx]  = 1'b1;
          end
        end
        KindRefresh: begin
          if (phase_q != PhIdle) begin
            rej = 1'b1;
          end else begin
            led_d = '0;
            sub_d = '0;
            bit_d = '0;
            if (cfg_i.led_count == '0) begin
              go_latch = 1'b1;
            end else begin
              go_high = 1'b1;
              ram_re  = 1'b1;
            end
          end
        end
        KindTick: begin
          if (phase_q != PhIdle) begin
            if (left_dec != '0) begin
              ticks_d = left_dec;
              pend_d  = 1'b0;
            end else begin
              case (phase_q)
                PhHigh: begin
                  phase_d = PhLow;
                  pend_d  = 1'b0;
                  ticks_d = TickW'(pulse_len(cur_bit ? cfg_i.short_ticks
                                                     : cfg_i.long_ticks));
                end
                PhLow: begin
                  if (bit_q == 3'd7) begin
                    bit_d = '0;
                    if (sub_q == SubLast) begin
                      sub_d   = '0;
                      led_new = led_next;
                    end else begin
                      sub_d = sub_q + 2'd1;
                    end
                    led_d = led_new;
                    // frame ends at the first byte boundary past the count
                    if (led_new >= cfg_i.led_count) begin
                      go_latch = 1'b1;
                    end else begin
                      go_high = 1'b1;
                      if (sub_q == SubLast) begin
                        ram_re    = 1'b1;
                        ram_raddr = led_next[LedIdxW-1:0];
                      end
                    end
                  end else begin
                    bit_d   = bit_q + 3'd1;
                    go_high = 1'b1;
                  end
                end
                default: begin
                  phase_d = PhIdle;
                  ticks_d = '0;
                  pend_d  = 1'b0;
                  led_d   = '0;
                  sub_d   = '0;
                  bit_d   = '0;
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (go_high) begin
      // pulse length waits for the bit, which may still be in flight
      phase_d      = PhHigh;
      pend_d       = 1'b1;
      snap_long_d  = pulse_len(cfg_i.long_ticks);
      snap_short_d = pulse_len(cfg_i.short_ticks);
    end
    if (go_latch) begin
      phase_d = PhLatch;
      pend_d  = 1'b0;
      ticks_d = latch_len(cfg_i.latch_ticks);
    end

    if (head_i.kind == KindTick) begin
      lvl = (phase_q == PhHigh);
      bsy = (phase_q != PhIdle);
    end else begin
      lvl = (phase_d == PhHigh);
      bsy = (phase_d != PhIdle);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      word_q <= cur_word;
    end
    if (ram_re) begin
      hit_q <= vld_q[ram_raddr];
    end
    if (take) begin
      pin_level_q <= lvl;
      busy_res_q  <= bsy;
      rejected_q  <= rej;
    end
    ticks_q      <= ticks_d;
    snap_long_q  <= snap_long_d;
    snap_short_q <= snap_short_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      led_q       <= '0;
      sub_q       <= '0;
      bit_q       <= '0;
      pend_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      led_q       <= led_d;
      sub_q       <= sub_d;
      bit_q       <= bit_d;
      pend_q      <= pend_d;
      rd_pend_q   <= ram_re;
      vld_q       <= vld_d;
      out_valid_q <= take || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pin_level_o = pin_level_q;
  assign busy_res_o  = busy_res_q;
  assign rejected_o  = rejected_q;

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (phase_q == PhIdle))
    else $error("colour store written during a frame");

  a_led_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHigh || phase_q == PhLow) |-> (int'(led_q) < LedMax))
    else $error("led position beyond store while sending");

  a_read_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> !ram_re)
    else $error("back to back store reads");

  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (led_q == '0 && sub_q == '0 && bit_q == '0))
    else $error("position not cleared while idle");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhIdle) |-> (sub_q <= SubLast))
    else $error("byte in led out of range");

endmodule
`default_nettype wire

>>> rtl/core/addressable_led_strip_driver_unit.sv
// top level of the addressable led strip driver
`default_nettype none
// Drives a single-wire addressable led strip. A colour store of LedMax
// entries holds one 24-bit colour per led and is sent green, red, blue,
// msb first. Words on the input channel are commands: set colour, start a
// refresh, one tick of time, or no-op. Every word gives exactly one result
// word with the data line level, a busy flag and a rejected flag. Rate:
// one word per clock sustained while the result channel does not stall;
// an accepted word is written into the queue, and the sequencer takes it
// from the queue head and writes its result into the result register. A
// two-entry queue sits between the decoding front end and the sequencer,
// and it keeps taking words while a result waits in the result register,
// until it is full. The colour store is a ram with registered read; the
// next led's colour is fetched once per led and a fresh read is bypassed
// into the sequencer, so pulses of one tick still time correctly. Entries
// never written since reset read as black through one valid flop per led,
// so no clearing pass follows reset. Configuration writes are registered
// and the port is always ready.
module addressable_led_strip_driver_unit
  import aled_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // command channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CmdW-1:0]     command_i,
  input  wire logic [IdxInW-1:0]   led_index_i,
  input  wire logic [ColorW-1:0]   color_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     pin_level_o,
  output logic                     busy_res_o,
  output logic                     rejected_o,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t   cfg_q;
  logic   cfg_we;
  logic [CountFieldW-1:0] count_raw;
  logic [LedCntW-1:0]     count_sat;

  logic   q_full;
  logic   push;
  item_t  item;
  logic   head_valid;
  item_t  head;
  logic   pop;

  // config registers, always writable
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // led count saturates at the store size
  assign count_raw = cfg_data_i[CountFieldW-1:0];
  assign count_sat = (int'(count_raw) > LedMax) ? LedCntW'(LedMax)
                                                : LedCntW'(count_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_count   <= LedCntW'(LedMax);
      cfg_q.long_ticks  <= LongTicksRst;
      cfg_q.short_ticks <= ShortTicksRst;
      cfg_q.latch_ticks <= LatchTicksRst;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CfgLedCount:   cfg_q.led_count   <= count_sat;
        CfgLongTicks:  cfg_q.long_ticks  <= cfg_data_i[PulseW-1:0];
        CfgShortTicks: cfg_q.short_ticks <= cfg_data_i[PulseW-1:0];
        CfgLatchTicks: cfg_q.latch_ticks <= cfg_data_i[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  // decode and range check of incoming words
  aled_front u_front (
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .led_index_i (led_index_i),
    .color_i     (color_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (item)
  );

  // decouples front and sequencer
  aled_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // colour store, frame timing and result register
  aled_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pin_level_o  (pin_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

endmodule
`default_nettype wire
